### src/oore_pkg.sv
// overwrite-oldest event ring: shared constants and input codes
// no dependencies; imported by overwrite_oldest_event_ring
`timescale 1ns / 1ps
`default_nettype none

package oore_pkg;

	// field widths fixed by the transaction layout
	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned SEQ_W     = 64;
	localparam int unsigned CNT_W     = 6;
	localparam int unsigned DROP_W    = 32;

	// one stored entry: sequence stamp above payload
	localparam int unsigned ENTRY_W = SEQ_W + PAYLOAD_W;

	// input kind codes
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef logic [PAYLOAD_W-1:0] payload_t;
	typedef logic [SEQ_W-1:0]     seq_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [DROP_W-1:0]    drop_t;

endpackage : oore_pkg

`default_nettype wire

### src/overwrite_oldest_event_ring.sv
// overwrite-oldest event ring, top level with the entry memory
// depends on oore_pkg
`timescale 1ns / 1ps
`default_nettype none

// Event ring of RING_DEPTH entries that overwrites its oldest entry when full.
// A push (kind = 0) gives no result; pushes may follow each other in every
// cycle while busy is low. A read (kind = 1) gives 1 + N results, where N =
// min(max_events, BATCH_MAX, stored entries): the header comes out in the
// cycle after the read is taken, and one entry per cycle follows it, each
// read from the single-port entry memory in the cycle before it is shown.
// busy is high from the header until the final entry is read, or only with
// the header on an empty read, so the next transaction can be taken in the
// cycle in which the final entry is shown, or in the cycle after the header
// on an empty read. Results are shown for exactly one cycle with strobe high
// and cannot be held off; the last result of a read carries last = 1. The
// entry memory is not cleared: only written entries are read.
module overwrite_oldest_event_ring #(
	parameter int unsigned RING_DEPTH = 128,
	parameter int unsigned BATCH_MAX  = 63
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire                   kind,
	input  wire  oore_pkg::payload_t event_payload,
	input  wire  oore_pkg::cnt_t  max_events,
	output logic                  strobe,
	output logic                  is_header,
	output oore_pkg::cnt_t        batch_count,
	output oore_pkg::drop_t       dropped_count,
	output oore_pkg::seq_t        entry_sequence,
	output oore_pkg::payload_t    entry_payload,
	output logic                  last
);
	import oore_pkg::*;

	localparam int unsigned AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned FW    = $clog2(RING_DEPTH + 1);
	localparam int unsigned SUM_W = ((FW > CNT_W) ? FW : CNT_W) + 1;

	// ring pointers and counters
	logic [AW-1:0] oldest_q;
	logic [FW-1:0] fill_q;
	drop_t         drop_q;
	seq_t          seq_q;

	// read run control
	logic          act_q;
	logic          hdr_q;
	cnt_t          hdr_cnt_q;
	drop_t         hdr_drop_q;
	logic [AW-1:0] rd_ptr_q;
	cnt_t          rem_q;

	// memory read stage
	logic                ent_v_s1;
	logic                ent_last_s1;
	logic [ENTRY_W-1:0]  rdata_s1;

	logic [ENTRY_W-1:0]  mem [RING_DEPTH];

	logic                take;
	logic                push;
	logic                rd_go;
	logic                full;
	logic [AW-1:0]       oldest_inc;
	logic [SUM_W-1:0]    tail_sum;
	logic [AW-1:0]       wr_addr;
	cnt_t                want;
	logic [SUM_W-1:0]    fill_x;
	logic [SUM_W-1:0]    want_x;
	cnt_t                count;
	logic [SUM_W-1:0]    adv_sum;
	logic [AW-1:0]       oldest_adv;
	logic                issue;

	// transaction accept and decode
	assign take  = start && !busy;
	assign push  = take && (kind == KIND_PUSH);
	assign rd_go = take && (kind == KIND_READ);
	assign busy  = act_q;

	// push address: the oldest slot when full, else the slot after the newest
	assign full       = (fill_q == FW'(RING_DEPTH));
	assign oldest_inc = (oldest_q == AW'(RING_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign tail_sum   = SUM_W'(oldest_q) + SUM_W'(fill_q);
	always_comb begin
		if (full) begin
			wr_addr = oldest_q;
		end else if (tail_sum >= SUM_W'(RING_DEPTH)) begin
			wr_addr = AW'(tail_sum - SUM_W'(RING_DEPTH));
		end else begin
			wr_addr = AW'(tail_sum);
		end
	end

	// read size: request clipped to the batch limit and the stored entries
	assign want   = (max_events > CNT_W'(BATCH_MAX)) ? CNT_W'(BATCH_MAX) : max_events;
	assign fill_x = SUM_W'(fill_q);
	assign want_x = SUM_W'(want);
	assign count  = (fill_x < want_x) ? CNT_W'(fill_q) : want;
	assign adv_sum = SUM_W'(oldest_q) + SUM_W'(count);
	assign oldest_adv = (adv_sum >= SUM_W'(RING_DEPTH)) ?
		AW'(adv_sum - SUM_W'(RING_DEPTH)) : AW'(adv_sum);

	// ring state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q   <= '0;
			drop_q   <= '0;
			seq_q    <= '0;
		end else if (push) begin
			seq_q <= seq_q + 1'b1;
			if (full) begin
				oldest_q <= oldest_inc;
				drop_q   <= drop_q + 1'b1;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end else if (rd_go) begin
			oldest_q <= oldest_adv;
			fill_q   <= fill_q - FW'(count);
			drop_q   <= '0;
		end
	end

	// entry memory write
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_addr] <= {seq_q + 1'b1, event_payload};
		end
	end

	// read run: header in the first busy cycle, one entry read per cycle
	assign issue = act_q && (rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			hdr_q <= 1'b0;
			rem_q <= '0;
		end else if (rd_go) begin
			act_q <= 1'b1;
			hdr_q <= 1'b1;
			rem_q <= count;
		end else begin
			hdr_q <= 1'b0;
			if (issue) begin
				rem_q <= rem_q - 1'b1;
				act_q <= (rem_q != CNT_W'(1));
			end else begin
				act_q <= 1'b0;
			end
		end
	end

	// header fields and read pointer
	always_ff @(posedge clk) begin
		if (rd_go) begin
			hdr_cnt_q  <= count;
			hdr_drop_q <= drop_q;
			rd_ptr_q   <= oldest_q;
		end else if (issue) begin
			rd_ptr_q <= (rd_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		end
	end

	// memory read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_v_s1 <= 1'b0;
		end else begin
			ent_v_s1 <= issue;
		end
	end

	// registered memory read data
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1    <= mem[rd_ptr_q];
			ent_last_s1 <= (rem_q == CNT_W'(1));
		end
	end

	// result ports
	assign strobe         = hdr_q || ent_v_s1;
	assign is_header      = hdr_q;
	assign batch_count    = hdr_q ? hdr_cnt_q : '0;
	assign dropped_count  = hdr_q ? hdr_drop_q : '0;
	assign entry_sequence = hdr_q ? '0 : rdata_s1[ENTRY_W-1:PAYLOAD_W];
	assign entry_payload  = hdr_q ? '0 : rdata_s1[PAYLOAD_W-1:0];
	assign last           = hdr_q ? (hdr_cnt_q == '0) : ent_last_s1;

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(hdr_q && ent_v_s1))
		else $error("header and entry shown in the same cycle");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(RING_DEPTH))
		else $error("fill count above ring depth");

	a_hdr_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_go |=> (hdr_q && act_q))
		else $error("accepted read gave no header");

	a_entry_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		ent_v_s1 |-> $past(act_q))
		else $error("entry shown outside a read run");

endmodule : overwrite_oldest_event_ring

`default_nettype wire
